>>> sv/olms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olms_pkg: shared types and constants of the masked Laplacian stencil core
// Holds the grid limits, the field widths and the register index codes.
// ----------------------------------------------------------------------------
package olms_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int VALUE_BITS   = 32;
  localparam int RESULT_BITS  = VALUE_BITS + 3;
  localparam int COL_BITS     = 10;
  localparam int ROW_BITS     = 12;
  localparam int WIDTH_BITS   = 11;
  localparam int HEIGHT_BITS  = 13;
  localparam int CFG_DATA_BITS = 13;
  localparam int CFG_INDEX_BITS = 1;

  // A line buffer entry holds two rows of one column, each a value and a flag.
  localparam int ENTRY_BITS   = 2 * (VALUE_BITS + 1);

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t REG_GRID_WIDTH  = 1'b0;
  localparam cfg_index_t REG_GRID_HEIGHT = 1'b1;

  typedef logic signed [VALUE_BITS-1:0]  value_t;
  typedef logic signed [RESULT_BITS-1:0] result_t;
  typedef logic [COL_BITS-1:0]           col_t;
  typedef logic [ROW_BITS-1:0]           row_t;

endpackage : olms_pkg
`default_nettype wire

>>> sv/obstacle_masked_laplacian_stencil_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// obstacle_masked_laplacian_stencil_core: streamed five-point Laplacian
// Takes grid cells in raster order and gives the obstacle-masked Poisson
// operator for every interior cell, one row and one column after the centre.
// ----------------------------------------------------------------------------
// The cell word that completes a window waits in stage one for its line
// buffer read; the stencil result is then held in the result register.
// Throughput: one cell word per cycle unless a result stalls; set by the
// single read and single write port of the line buffer, used once per cell.
// Reset clears the counters, the stage valid and the result valid; the line
// buffer memory is not cleared, as every result reads only rows of its frame.
module obstacle_masked_laplacian_stencil_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration port
  input  wire logic                             cfg_write_enable,
  input  wire olms_pkg::cfg_index_t             cfg_index,
  input  wire logic [olms_pkg::CFG_DATA_BITS-1:0] cfg_data,
  // cell stream
  input  wire logic                             cell_valid,
  output logic                                  cell_ready,
  input  wire logic signed [olms_pkg::VALUE_BITS-1:0] cell_value,
  input  wire logic                             cell_is_obstacle,
  // result stream
  output logic                                  result_valid,
  input  wire logic                             result_ready,
  output logic signed [olms_pkg::RESULT_BITS-1:0] stencil_value,
  output logic [olms_pkg::COL_BITS-1:0]         center_column,
  output logic [olms_pkg::ROW_BITS-1:0]         center_row,
  output logic                                  last_of_frame
);

  import olms_pkg::*;

  // Grid size in use, kept already clamped to its legal range.
  logic [WIDTH_BITS-1:0]  grid_w;
  logic [HEIGHT_BITS-1:0] grid_h;

  // Position of the next cell to be accepted.
  col_t col_count;
  row_t row_count;

  // Stage one: the accepted cell, waiting for its line buffer read data.
  logic   s1_valid;
  value_t s1_value;
  logic   s1_flag;
  col_t   s1_col;
  row_t   s1_row;

  // One line buffer entry holds the middle row (r-1) and the upper row (r-2)
  // of a column, each as a value with its obstacle flag.
  logic [ENTRY_BITS-1:0] line_mem [MAX_WIDTH];
  logic [ENTRY_BITS-1:0] line_rd;

  // The four window cells that the stencil reads: upper row at c-1, middle
  // row at c-2 and c-1 (the centre), lower row at c-1.
  value_t win_up_v, win_left_v, win_ctr_v, win_down_v;
  logic   win_up_f, win_left_f, win_ctr_f, win_down_f;

  value_t mid_v, up_v;
  logic   mid_f, up_f;

  logic cell_accept;
  logic s1_has_result;
  logic s1_advance;
  logic col_wrap;
  logic row_wrap;

  logic signed [VALUE_BITS:0] diff_up, diff_left, diff_right, diff_down;
  result_t stencil_next;

  logic [WIDTH_BITS-1:0]  width_clamped;
  logic [HEIGHT_BITS-1:0] height_clamped;

  assign {mid_v, mid_f, up_v, up_f} = line_rd;

  // An interior centre exists once the window spans two full rows and two
  // columns of the current row. Column and row never exceed the grid size.
  assign s1_has_result = (s1_col >= col_t'(2)) && (s1_row >= row_t'(2));

  // The stage retires a border cell at once; an interior cell needs room in
  // the result register, which frees up in the same cycle it is taken.
  assign s1_advance = s1_valid && (!s1_has_result || !result_valid || result_ready);
  assign cell_ready = !s1_valid || s1_advance;
  assign cell_accept = cell_valid && cell_ready;

  assign col_wrap = ({1'b0, col_count} + WIDTH_BITS'(1)) == grid_w;
  assign row_wrap = ({1'b0, row_count} + HEIGHT_BITS'(1)) == grid_h;

  // Clamp the written values into the usable ranges.
  always_comb begin
    width_clamped = cfg_data[WIDTH_BITS-1:0];
    if (width_clamped < WIDTH_BITS'(3)) begin
      width_clamped = WIDTH_BITS'(3);
    end else if (width_clamped > WIDTH_BITS'(MAX_WIDTH)) begin
      width_clamped = WIDTH_BITS'(MAX_WIDTH);
    end
    height_clamped = cfg_data[HEIGHT_BITS-1:0];
    if (height_clamped < HEIGHT_BITS'(3)) begin
      height_clamped = HEIGHT_BITS'(3);
    end else if (height_clamped > HEIGHT_BITS'(MAX_HEIGHT)) begin
      height_clamped = HEIGHT_BITS'(MAX_HEIGHT);
    end
  end

  // The operator n * centre - sum(free neighbours) is formed as the sum of
  // (centre - neighbour) over the free neighbours, which needs no multiply.
  always_comb begin
    diff_up    = win_up_f   ? '0 : (VALUE_BITS+1)'(win_ctr_v) - (VALUE_BITS+1)'(win_up_v);
    diff_left  = win_left_f ? '0 : (VALUE_BITS+1)'(win_ctr_v) - (VALUE_BITS+1)'(win_left_v);
    diff_right = mid_f      ? '0 : (VALUE_BITS+1)'(win_ctr_v) - (VALUE_BITS+1)'(mid_v);
    diff_down  = win_down_f ? '0 : (VALUE_BITS+1)'(win_ctr_v) - (VALUE_BITS+1)'(win_down_v);
    if (win_ctr_f) begin
      stencil_next = '0;
    end else begin
      stencil_next = RESULT_BITS'(diff_up) + RESULT_BITS'(diff_left)
                   + RESULT_BITS'(diff_right) + RESULT_BITS'(diff_down);
    end
  end

  // Configuration registers. Any write restarts the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_w <= WIDTH_BITS'(64);
      grid_h <= HEIGHT_BITS'(64);
    end else if (cfg_write_enable) begin
      case (cfg_index)
        REG_GRID_WIDTH: begin
          grid_w <= width_clamped;
        end
        REG_GRID_HEIGHT: begin
          grid_h <= height_clamped;
        end
        default: begin
        end
      endcase
    end
  end

  // Raster position counters advance on every accepted cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (cfg_write_enable) begin
      col_count <= '0;
      row_count <= '0;
    end else if (cell_accept) begin
      if (col_wrap) begin
        col_count <= '0;
        row_count <= row_wrap ? '0 : row_count + row_t'(1);
      end else begin
        col_count <= col_count + col_t'(1);
      end
    end
  end

  // Stage one control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cell_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage one payload.
  always_ff @(posedge clk) begin
    if (cell_accept) begin
      s1_value <= cell_value;
      s1_flag  <= cell_is_obstacle;
      s1_col   <= col_count;
      s1_row   <= row_count;
    end
  end

  // Line buffer: read at acceptance, written back when the cell retires. The
  // same column is read again only a full row later, after the write.
  always_ff @(posedge clk) begin
    if (cell_accept) begin
      line_rd <= line_mem[col_count];
    end
    if (s1_advance) begin
      line_mem[s1_col] <= {s1_value, s1_flag, mid_v, mid_f};
    end
  end

  // The window shifts one column as each cell retires.
  always_ff @(posedge clk) begin
    if (s1_advance) begin
      win_up_v   <= up_v;
      win_up_f   <= up_f;
      win_left_v <= win_ctr_v;
      win_left_f <= win_ctr_f;
      win_ctr_v  <= mid_v;
      win_ctr_f  <= mid_f;
      win_down_v <= s1_value;
      win_down_f <= s1_flag;
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_advance && s1_has_result) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (s1_advance && s1_has_result) begin
      stencil_value <= stencil_next;
      center_column <= s1_col - col_t'(1);
      center_row    <= s1_row - row_t'(1);
      last_of_frame <= ({1'b0, s1_col} == grid_w - WIDTH_BITS'(1))
                    && ({1'b0, s1_row} == grid_h - HEIGHT_BITS'(1));
    end
  end

endmodule : obstacle_masked_laplacian_stencil_core
`default_nettype wire

>>> sv/olms_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olms_checker: port-level checks for the masked Laplacian stencil core
// Watches the result stream against reset and the cell stream.
// ----------------------------------------------------------------------------
module olms_checker (
  input wire logic                                   clk,
  input wire logic                                   rst,
  input wire logic                                   cell_valid,
  input wire logic                                   cell_ready,
  input wire logic                                   result_valid,
  input wire logic                                   result_ready,
  input wire logic signed [olms_pkg::RESULT_BITS-1:0] stencil_value,
  input wire logic [olms_pkg::COL_BITS-1:0]          center_column,
  input wire logic [olms_pkg::ROW_BITS-1:0]          center_row
);

  import olms_pkg::*;

  // A waiting result word holds until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(stencil_value))
    else $error("result word changed while stalled");

  // Reset empties the result register.
  assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid after reset");

  // Results belong to interior cells only.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (center_column != '0) && (center_row != '0))
    else $error("result for a border cell");

  // A fresh result needs a cell word accepted before it, through stage one.
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(cell_valid && cell_ready, 2))
    else $error("result word without a cell word");

endmodule : olms_checker

bind obstacle_masked_laplacian_stencil_core olms_checker u_olms_checker (.*);
`default_nettype wire
